/* hw/rtl/ticpu_pkg.sv */
// Shared types and constants for the tiny CPU execute unit.
// Opcodes, sequencer states, register indexes and the remainder unit status.
// No dependencies.
`default_nettype none

package ticpu_pkg;

   typedef logic [15:0] word_type;
   typedef logic [4:0]  opcode_type;
   typedef logic        csr_index_type;

   localparam opcode_type OP_MOV  = 5'd0;
   localparam opcode_type OP_MOVI = 5'd1;
   localparam opcode_type OP_JE   = 5'd2;
   localparam opcode_type OP_JN   = 5'd3;
   localparam opcode_type OP_JG   = 5'd4;
   localparam opcode_type OP_JL   = 5'd5;
   localparam opcode_type OP_CMP  = 5'd6;
   localparam opcode_type OP_ADD  = 5'd7;
   localparam opcode_type OP_ADDI = 5'd8;
   localparam opcode_type OP_SUB  = 5'd9;
   localparam opcode_type OP_SUBI = 5'd10;
   localparam opcode_type OP_MOD  = 5'd11;
   localparam opcode_type OP_MODI = 5'd12;
   localparam opcode_type OP_AND  = 5'd13;
   localparam opcode_type OP_OR   = 5'd14;
   localparam opcode_type OP_XOR  = 5'd15;
   localparam opcode_type OP_BSL  = 5'd16;
   localparam opcode_type OP_BSR  = 5'd17;
   localparam opcode_type OP_BSLI = 5'd18;
   localparam opcode_type OP_BSRI = 5'd19;
   localparam opcode_type OP_LDW  = 5'd20;
   localparam opcode_type OP_STW  = 5'd21;
   localparam opcode_type OP_LDB  = 5'd22;
   localparam opcode_type OP_STB  = 5'd23;
   localparam opcode_type OP_PUSH = 5'd24;
   localparam opcode_type OP_POP  = 5'd25;
   localparam opcode_type OP_HALT = 5'd26;

   localparam csr_index_type CSR_PROGRAM_START = 1'b0;
   localparam csr_index_type CSR_STACK_ADDRESS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_B,
      ST_RD_A,
      ST_EXEC,
      ST_MOD,
      ST_ADDR,
      ST_MEM0,
      ST_MEM1,
      ST_MEM2,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

`default_nettype wire

/* hw/rtl/tiny_cpu_execute_unit.sv */
// Tiny CPU execute unit: sequencer, register file and byte data memory.
// Register ops and jumps: RD_B, RD_A, EXEC, COMMIT; MOD/MODI add MOD (16-step remainder
// unit), memory ops MEM0 to MEM2 and ADDR if MEM_BYTES is below 65536 (address reduced in
// the same unit). Items after halt skip to COMMIT. Result is registered; next item accepted
// while it waits. Reset: synchronous; registers, pc and halt cleared, then CLEAR zeroes memory.
// Depends on ticpu_pkg, ticpu_ram, ticpu_rem, ticpu_alu.
`default_nettype none

module tiny_cpu_execute_unit #(
   parameter int MEM_BYTES = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ticpu_pkg::word_type      req_instruction,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ticpu_pkg::word_type           rsp_pc_value,
   output logic                          rsp_jump_taken,
   output logic                          rsp_halted,
   output logic                          rsp_illegal_opcode,
   output logic                          rsp_reg_written,
   output logic [2:0]                    rsp_reg_index,
   output ticpu_pkg::word_type           rsp_reg_value,
   input  wire logic                     csr_write_enable,
   input  wire ticpu_pkg::csr_index_type csr_index,
   input  wire ticpu_pkg::word_type      csr_write_data
);

   import ticpu_pkg::*;

   localparam int            AW          = $clog2(MEM_BYTES);
   localparam logic [AW-1:0] MEM_LAST    = AW'(MEM_BYTES - 1);
   localparam bit            ADDR_WRAP   = (MEM_BYTES < 65536);
   localparam word_type      MEM_DIVISOR = 16'(MEM_BYTES);

   state_type     state_ff, state_in;
   word_type      inst_ff, inst_in;
   word_type      a_ff, a_in;
   word_type      b_ff, b_in;
   word_type      msrc_ff, msrc_in;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [7:0]    lo_ff, lo_in;
   logic [AW-1:0] clr_ff, clr_in;
   word_type      pc_ff, pc_in;
   word_type      stack_ff, stack_in;
   logic          halted_ff, halted_in;
   logic [7:0]    rf_valid_ff, rf_valid_in;
   logic          rfv_rd_ff;

   word_type      res_val_ff, res_val_in;
   logic          res_wr_ff, res_wr_in;
   logic [2:0]    res_idx_ff, res_idx_in;
   logic          res_jump_ff, res_jump_in;
   logic          res_ill_ff, res_ill_in;
   logic          res_halt_ff, res_halt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_pc_ff;
   logic          rsp_jump_ff;
   logic          rsp_halted_ff;
   logic          rsp_ill_ff;
   logic          rsp_wr_ff;
   logic [2:0]    rsp_idx_ff;
   word_type      rsp_val_ff;

   opcode_type    op;
   logic [2:0]    ra;
   logic [2:0]    rb;
   logic [7:0]    imm8;
   word_type      imm11;
   logic          is_mod;
   logic          is_jump;
   word_type      mod_divisor;
   word_type      mem_src;
   word_type      st_word;
   logic [AW-1:0] maddr2;
   logic          out_free;
   logic          commit;

   logic          rf_wr_en;
   logic [2:0]    rf_rd_addr;
   word_type      rf_rd_data;
   word_type      rf_word;
   word_type      alu_result;

   logic          mem_wr_en;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic          rem_start;
   word_type      rem_dividend;
   word_type      rem_divisor;
   rem_stat_type  rem_stat;
   word_type      rem_result;

   assign op          = opcode_type'(inst_ff[4:0]);
   assign ra          = inst_ff[7:5];
   assign rb          = inst_ff[10:8];
   assign imm8        = inst_ff[15:8];
   assign imm11       = {5'b0, inst_ff[15:5]};
   assign is_mod      = (op == OP_MOD) || (op == OP_MODI);
   assign is_jump     = (op inside {OP_JE, OP_JN, OP_JG, OP_JL});
   assign mod_divisor = (op == OP_MOD) ? b_ff : {8'b0, imm8};
   assign mem_src     = (op == OP_PUSH || op == OP_POP) ? stack_ff : b_ff;
   assign st_word     = (op == OP_PUSH) ? imm11 : a_ff;
   assign maddr2      = (msrc_ff == 16'hffff || maddr_ff == MEM_LAST) ? '0
                                                                      : maddr_ff + AW'(1);
   assign rf_word     = rfv_rd_ff ? rf_rd_data : '0;
   assign rf_rd_addr  = (state_ff == ST_RD_A) ? (is_jump ? 3'd0 : ra) : rb;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);

   assign rem_dividend = (state_ff == ST_EXEC && is_mod) ? rf_word : mem_src;
   assign rem_divisor  = is_mod ? mod_divisor : MEM_DIVISOR;

   ticpu_ram #(
      .WIDTH (16),
      .DEPTH (8)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (res_idx_ff),
      .wr_data (res_val_ff),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd_data)
   );

   ticpu_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_datamem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   ticpu_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .stat      (rem_stat),
      .remainder (rem_result)
   );

   ticpu_alu u_alu (
      .op     (op),
      .a      (rf_word),
      .b      (b_ff),
      .imm8   (imm8),
      .result (alu_result)
   );

   always_comb begin
      state_in    = state_ff;
      inst_in     = inst_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      msrc_in     = msrc_ff;
      maddr_in    = maddr_ff;
      lo_in       = lo_ff;
      clr_in      = clr_ff;
      pc_in       = pc_ff;
      stack_in    = stack_ff;
      halted_in   = halted_ff;
      rf_valid_in = rf_valid_ff;
      res_val_in  = res_val_ff;
      res_wr_in   = res_wr_ff;
      res_idx_in  = res_idx_ff;
      res_jump_in = res_jump_ff;
      res_ill_in  = res_ill_ff;
      res_halt_in = res_halt_ff;
      rf_wr_en    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_addr    = maddr_ff;
      mem_wdata   = '0;
      rem_start   = 1'b0;
      commit      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_addr  = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == MEM_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               inst_in     = req_instruction;
               res_val_in  = '0;
               res_wr_in   = 1'b0;
               res_idx_in  = '0;
               res_jump_in = 1'b0;
               res_ill_in  = 1'b0;
               res_halt_in = 1'b0;
               state_in    = halted_ff ? ST_COMMIT : ST_RD_B;
            end
         end
         ST_RD_B: begin
            state_in = ST_RD_A;
         end
         ST_RD_A: begin
            b_in     = rf_word;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            a_in = rf_word;
            case (op)
               OP_MOD, OP_MODI: begin
                  if (mod_divisor == '0) begin
                     state_in = ST_COMMIT;
                  end else begin
                     rem_start = 1'b1;
                     state_in  = ST_MOD;
                  end
               end
               OP_LDW, OP_STW, OP_LDB, OP_STB, OP_PUSH, OP_POP: begin
                  msrc_in = mem_src;
                  if (ADDR_WRAP) begin
                     rem_start = 1'b1;
                     state_in  = ST_ADDR;
                  end else begin
                     maddr_in = mem_src[AW-1:0];
                     state_in = ST_MEM0;
                  end
               end
               OP_JE: begin
                  res_jump_in = (rf_word == 16'd1);
                  state_in    = ST_COMMIT;
               end
               OP_JN: begin
                  res_jump_in = (rf_word != 16'd1);
                  state_in    = ST_COMMIT;
               end
               OP_JG: begin
                  res_jump_in = (rf_word > 16'd1);
                  state_in    = ST_COMMIT;
               end
               OP_JL: begin
                  res_jump_in = (rf_word == 16'd0);
                  state_in    = ST_COMMIT;
               end
               OP_HALT: begin
                  res_halt_in = 1'b1;
                  state_in    = ST_COMMIT;
               end
               OP_MOV, OP_MOVI, OP_CMP, OP_ADD, OP_ADDI, OP_SUB, OP_SUBI,
               OP_AND, OP_OR, OP_XOR, OP_BSL, OP_BSR, OP_BSLI, OP_BSRI: begin
                  res_wr_in  = 1'b1;
                  res_val_in = alu_result;
                  res_idx_in = (op == OP_CMP) ? 3'd0 : ra;
                  state_in   = ST_COMMIT;
               end
               default: begin
                  res_ill_in  = 1'b1;
                  res_halt_in = 1'b1;
                  state_in    = ST_COMMIT;
               end
            endcase
         end
         ST_MOD: begin
            if (rem_stat.done) begin
               res_wr_in  = 1'b1;
               res_val_in = rem_result;
               res_idx_in = ra;
               state_in   = ST_COMMIT;
            end
         end
         ST_ADDR: begin
            if (rem_stat.done) begin
               maddr_in = rem_result[AW-1:0];
               state_in = ST_MEM0;
            end
         end
         ST_MEM0: begin
            case (op)
               OP_STB: begin
                  mem_wr_en = 1'b1;
                  mem_wdata = a_ff[7:0];
                  state_in  = ST_COMMIT;
               end
               OP_STW, OP_PUSH: begin
                  mem_wr_en = 1'b1;
                  mem_wdata = st_word[7:0];
                  state_in  = ST_MEM1;
               end
               default: begin
                  state_in = ST_MEM1;
               end
            endcase
         end
         ST_MEM1: begin
            mem_addr = maddr2;
            case (op)
               OP_LDB: begin
                  res_wr_in  = 1'b1;
                  res_val_in = {8'b0, mem_rdata};
                  res_idx_in = ra;
                  state_in   = ST_COMMIT;
               end
               OP_STW, OP_PUSH: begin
                  mem_wr_en = 1'b1;
                  mem_wdata = st_word[15:8];
                  state_in  = ST_COMMIT;
               end
               default: begin
                  lo_in    = mem_rdata;
                  state_in = ST_MEM2;
               end
            endcase
         end
         ST_MEM2: begin
            res_wr_in  = 1'b1;
            res_val_in = {mem_rdata, lo_ff};
            res_idx_in = ra;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               commit   = 1'b1;
               rf_wr_en = res_wr_ff;
               if (res_wr_ff) begin
                  rf_valid_in[res_idx_ff] = 1'b1;
               end
               if (res_jump_ff) begin
                  pc_in = imm11;
               end
               if (res_halt_ff) begin
                  halted_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROGRAM_START: pc_in    = csr_write_data;
            CSR_STACK_ADDRESS: stack_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         stack_ff     <= '0;
         halted_ff    <= 1'b0;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         stack_ff     <= stack_in;
         halted_ff    <= halted_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inst_ff     <= inst_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      msrc_ff     <= msrc_in;
      maddr_ff    <= maddr_in;
      lo_ff       <= lo_in;
      rfv_rd_ff   <= rf_valid_ff[rf_rd_addr];
      res_val_ff  <= res_val_in;
      res_wr_ff   <= res_wr_in;
      res_idx_ff  <= res_idx_in;
      res_jump_ff <= res_jump_in;
      res_ill_ff  <= res_ill_in;
      res_halt_ff <= res_halt_in;
      if (commit) begin
         rsp_pc_ff     <= pc_in;
         rsp_jump_ff   <= res_jump_ff;
         rsp_halted_ff <= halted_in;
         rsp_ill_ff    <= res_ill_ff;
         rsp_wr_ff     <= res_wr_ff;
         rsp_idx_ff    <= res_idx_ff;
         rsp_val_ff    <= res_val_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pc_value       = rsp_pc_ff;
   assign rsp_jump_taken     = rsp_jump_ff;
   assign rsp_halted         = rsp_halted_ff;
   assign rsp_illegal_opcode = rsp_ill_ff;
   assign rsp_reg_written    = rsp_wr_ff;
   assign rsp_reg_index      = rsp_idx_ff;
   assign rsp_reg_value      = rsp_val_ff;

   a_rem_start_idle: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> !rem_stat.busy)
      else $error("remainder unit started while busy");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reg_written |-> rsp_reg_index == 3'd0 && rsp_reg_value == '0)
      else $error("register fields nonzero without a write");

   a_illegal_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal_opcode |-> rsp_halted && !rsp_reg_written)
      else $error("illegal opcode without halt");

endmodule

`default_nettype wire

/* hw/rtl/ticpu_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ticpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/ticpu_rem.sv */
// Shared iterative remainder unit, one quotient bit per cycle.
// Serves MOD/MODI and byte address reduction. Depends on ticpu_pkg.
`default_nettype none

module ticpu_rem (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire ticpu_pkg::word_type     dividend,
   input  wire ticpu_pkg::word_type     divisor,
   output ticpu_pkg::rem_stat_type      stat,
   output ticpu_pkg::word_type          remainder
);

   import ticpu_pkg::*;

   localparam logic [3:0] LAST_STEP = 4'hf;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   word_type    dvd_ff, dvd_in;
   word_type    dvs_ff, dvs_in;
   word_type    rem_ff, rem_in;
   logic [16:0] shifted;
   logic [16:0] trial;

   always_comb begin
      shifted = {rem_ff, dvd_ff[15]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (shifted >= {1'b0, dvs_ff}) ? trial[15:0] : shifted[15:0];
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hw/rtl/ticpu_alu.sv */
// Register-to-register and immediate ALU operations: move, compare, add, sub,
// logic and shifts. Depends on ticpu_pkg.
`default_nettype none

module ticpu_alu (
   input  wire ticpu_pkg::opcode_type op,
   input  wire ticpu_pkg::word_type   a,
   input  wire ticpu_pkg::word_type   b,
   input  wire logic [7:0]            imm8,
   output ticpu_pkg::word_type        result
);

   import ticpu_pkg::*;

   word_type   imm16;
   word_type   opnd;
   logic       big_shift;
   logic [3:0] sh;

   always_comb begin
      imm16     = {8'b0, imm8};
      opnd      = (op inside {OP_ADDI, OP_SUBI, OP_BSLI, OP_BSRI}) ? imm16 : b;
      big_shift = (opnd[15:4] != 12'd0);
      sh        = opnd[3:0];
      case (op)
         OP_MOV:            result = b;
         OP_MOVI:           result = imm16;
         OP_CMP:            result = (a < b) ? '0 : (a - b + 16'd1);
         OP_ADD, OP_ADDI:   result = a + opnd;
         OP_SUB, OP_SUBI:   result = a - opnd;
         OP_AND:            result = a & b;
         OP_OR:             result = a | b;
         OP_XOR:            result = a ^ b;
         OP_BSL, OP_BSLI:   result = big_shift ? '0 : (a << sh);
         OP_BSR, OP_BSRI:   result = big_shift ? '0 : (a >> sh);
         default:           result = '0;
      endcase
   end

endmodule

`default_nettype wire
